// File: sv/i2cm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types, codes and reset constants shared by the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] LONG_PHASE_RST  = 8'd40;
    localparam logic [7:0] MID_PHASE_RST   = 8'd20;
    localparam logic [7:0] SHORT_PHASE_RST = 8'd10;
    localparam logic [7:0] ACK_LIMIT_RST   = 8'd250;

    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_READ  = 3'd3;
    localparam logic [2:0] OP_WAIT  = 3'd4;

    typedef enum logic [1:0] {
        CFG_LONG  = 2'd0,
        CFG_MID   = 2'd1,
        CFG_SHORT = 2'd2,
        CFG_LIMIT = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_WAIT  = 3'd5
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_entry;

    typedef struct packed {
        logic [7:0] long_ticks;
        logic [7:0] mid_ticks;
        logic [7:0] short_ticks;
        logic [7:0] ack_limit;
    } t_cfg;

    function automatic logic [7:0] f_ticks(input logic [7:0] ticks);
        f_ticks = (ticks == 8'd0) ? 8'd1 : ticks;
    endfunction

endpackage

`default_nettype wire

// File: sv/i2cm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm interfaces
// Valid/ready channels for ticks, results and register writes.
// ----------------------------------------------------------------------------
interface i2cm_tick_if;
    logic       valid;
    logic       ready;
    logic       cmd_valid;
    logic [2:0] operation;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, cmd_valid, operation, tx_byte, send_ack, sda_in,
                    input ready);
    modport sink (input valid, cmd_valid, operation, tx_byte, send_ack, sda_in,
                  output ready);
endinterface

interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;

    modport source (output valid, scl_level, sda_level, sda_enable, busy_res, done_res,
                    rx_byte, ack_failed, input ready);
    modport sink (input valid, scl_level, sda_level, sda_enable, busy_res, done_res,
                  rx_byte, ack_failed, output ready);
endinterface

interface i2cm_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/i2cm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts ticks and classifies the offered command for the back end.
// ----------------------------------------------------------------------------
module i2cm_front (
    i2cm_tick_if.sink      i_tick,
    output logic           o_push,
    output i2cm_pkg::t_entry o_entry,
    input  logic           i_push_ready
);

    i2cm_pkg::t_cmd cmd;

    always_comb begin
        cmd = i2cm_pkg::CMD_NONE;
        if (i_tick.cmd_valid) begin
            case (i_tick.operation)
                i2cm_pkg::OP_START: cmd = i2cm_pkg::CMD_START;
                i2cm_pkg::OP_STOP:  cmd = i2cm_pkg::CMD_STOP;
                i2cm_pkg::OP_WRITE: cmd = i2cm_pkg::CMD_WRITE;
                i2cm_pkg::OP_READ:  cmd = i2cm_pkg::CMD_READ;
                i2cm_pkg::OP_WAIT:  cmd = i2cm_pkg::CMD_WAIT;
                default:            cmd = i2cm_pkg::CMD_NONE;
            endcase
        end
    end

    assign o_entry.cmd      = cmd;
    assign o_entry.tx_byte  = i_tick.tx_byte;
    assign o_entry.send_ack = i_tick.send_ack;
    assign o_entry.sda_in   = i_tick.sda_in;
    assign o_push           = i_tick.valid;
    assign i_tick.ready     = i_push_ready;

endmodule

`default_nettype wire

// File: sv/i2cm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_queue
// Small first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module i2cm_queue #(
    parameter int DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  i2cm_pkg::t_entry i_data,
    output logic             o_push_ready,
    output logic             o_valid,
    output i2cm_pkg::t_entry o_data,
    input  logic             i_pop
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    i2cm_pkg::t_entry r_mem [DEPTH];
    logic [PtrW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0]  r_count, n_count;
    logic             push_do, pop_do;

    assign o_push_ready = (r_count != FullCnt);
    assign o_valid      = (r_count != '0);
    assign o_data       = r_mem[r_rd_ptr];
    assign push_do      = i_push && o_push_ready;
    assign pop_do       = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push_do) begin
            n_wr_ptr = (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop_do) begin
            n_rd_ptr = (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push_do && !pop_do) begin
            n_count = r_count + 1'b1;
        end else if (pop_do && !push_do) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_do) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FullCnt)
        else $error("queue count beyond depth");

    a_pop_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_do && !push_do) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not follow a pop");

endmodule

`default_nettype wire

// File: sv/i2cm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_back
// Bus phase sequencer, delay registers and registered result stage.
// ----------------------------------------------------------------------------
module i2cm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    i2cm_cfg_if.sink         i_cfg,
    input  logic             i_valid,
    input  i2cm_pkg::t_entry i_entry,
    output logic             o_pop,
    i2cm_res_if.source       o_res
);

    typedef enum logic [14:0] {
        PH_IDLE    = 15'h0001,
        PH_ST1     = 15'h0002,
        PH_ST2     = 15'h0004,
        PH_SP1     = 15'h0008,
        PH_SP2     = 15'h0010,
        PH_W_LOW   = 15'h0020,
        PH_W_HIGH  = 15'h0040,
        PH_W_TAIL  = 15'h0080,
        PH_R_LOW   = 15'h0100,
        PH_R_HIGH  = 15'h0200,
        PH_A_LOW   = 15'h0400,
        PH_A_HIGH  = 15'h0800,
        PH_WA1     = 15'h1000,
        PH_WA2     = 15'h2000,
        PH_WA_POLL = 15'h4000
    } t_phase;

    i2cm_pkg::t_cfg r_cfg;
    t_phase         r_phase, n_phase;
    logic [3:0]     r_bit_count, n_bit_count;
    logic [7:0]     r_shift, n_shift;
    logic [7:0]     r_delay, n_delay;
    logic [7:0]     r_poll, n_poll;
    logic           r_scl, n_scl;
    logic           r_sda, n_sda;
    logic           r_sda_oe, n_sda_oe;
    logic           r_ack_to_send, n_ack_to_send;
    logic           r_fail, n_fail;
    logic [7:0]     r_rx, n_rx;
    logic           r_out_valid;
    logic           r_out_done;
    logic           done;
    logic           dly_exp;
    logic [7:0]     dly_dec;
    logic [3:0]     bc_inc;
    logic [8:0]     poll_inc;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_ticks  <= i2cm_pkg::LONG_PHASE_RST;
            r_cfg.mid_ticks   <= i2cm_pkg::MID_PHASE_RST;
            r_cfg.short_ticks <= i2cm_pkg::SHORT_PHASE_RST;
            r_cfg.ack_limit   <= i2cm_pkg::ACK_LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                i2cm_pkg::CFG_LONG:  r_cfg.long_ticks  <= i_cfg.data;
                i2cm_pkg::CFG_MID:   r_cfg.mid_ticks   <= i_cfg.data;
                i2cm_pkg::CFG_SHORT: r_cfg.short_ticks <= i_cfg.data;
                i2cm_pkg::CFG_LIMIT: r_cfg.ack_limit   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign o_pop    = i_valid && (!r_out_valid || o_res.ready);
    assign dly_exp  = (r_delay <= 8'd1);
    assign dly_dec  = dly_exp ? 8'd0 : r_delay - 8'd1;
    assign bc_inc   = r_bit_count + 4'd1;
    assign poll_inc = {1'b0, r_poll} + 9'd1;

    always_comb begin
        n_phase       = r_phase;
        n_bit_count   = r_bit_count;
        n_shift       = r_shift;
        n_delay       = r_delay;
        n_poll        = r_poll;
        n_scl         = r_scl;
        n_sda         = r_sda;
        n_sda_oe      = r_sda_oe;
        n_ack_to_send = r_ack_to_send;
        n_fail        = r_fail;
        n_rx          = r_rx;
        done          = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                case (i_entry.cmd)
                    i2cm_pkg::CMD_START: begin
                        n_sda_oe = 1'b1;
                        n_sda    = 1'b1;
                        n_scl    = 1'b1;
                        n_phase  = PH_ST1;
                        n_delay  = i2cm_pkg::f_ticks(r_cfg.long_ticks);
                    end
                    i2cm_pkg::CMD_STOP: begin
                        n_sda_oe = 1'b1;
                        n_scl    = 1'b0;
                        n_sda    = 1'b0;
                        n_phase  = PH_SP1;
                        n_delay  = i2cm_pkg::f_ticks(r_cfg.long_ticks);
                    end
                    i2cm_pkg::CMD_WRITE: begin
                        n_sda_oe    = 1'b1;
                        n_scl       = 1'b0;
                        n_bit_count = 4'd0;
                        n_sda       = i_entry.tx_byte[7];
                        n_shift     = {i_entry.tx_byte[6:0], 1'b0};
                        n_phase     = PH_W_LOW;
                        n_delay     = i2cm_pkg::f_ticks(r_cfg.mid_ticks);
                    end
                    i2cm_pkg::CMD_READ: begin
                        n_sda_oe      = 1'b0;
                        n_scl         = 1'b0;
                        n_shift       = 8'd0;
                        n_bit_count   = 4'd0;
                        n_ack_to_send = i_entry.send_ack;
                        n_phase       = PH_R_LOW;
                        n_delay       = i2cm_pkg::f_ticks(r_cfg.mid_ticks);
                    end
                    i2cm_pkg::CMD_WAIT: begin
                        n_sda_oe = 1'b0;
                        n_sda    = 1'b1;
                        n_poll   = 8'd0;
                        n_phase  = PH_WA1;
                        n_delay  = i2cm_pkg::f_ticks(r_cfg.short_ticks);
                    end
                    default: ;
                endcase
            end
            PH_ST1: begin
                n_delay = dly_dec;
                if (dly_exp) begin
                    n_sda   = 1'b0;
                    n_phase = PH_ST2;
                    n_delay = i2cm_pkg::f_ticks(r_cfg.long_ticks);
                end
            end
            PH_ST2: begin
                n_delay = dly_dec;
                if (dly_exp) begin
                    n_scl   = 1'b0;
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end
            end
            PH_SP1: begin
                n_delay = dly_dec;
                if (dly_exp) begin
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                    n_phase = PH_SP2;
                    n_delay = i2cm_pkg::f_ticks(r_cfg.long_ticks);
                end
            end
            PH_SP2: begin
                n_delay = dly_dec;
                if (dly_exp) begin
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end
            end
            PH_W_LOW: begin
                n_delay = dly_dec;
                if (dly_exp) begin
                    n_scl   = 1'b1;
                    n_phase = PH_W_HIGH;
                    n_delay = i2cm_pkg::f_ticks(r_cfg.mid_ticks);
                end
            end
            PH_W_HIGH: begin
                n_delay = dly_dec;
                if (dly_exp) begin
                    n_scl   = 1'b0;
                    n_phase = PH_W_TAIL;
                    n_delay = i2cm_pkg::f_ticks(r_cfg.mid_ticks);
                end
            end
            PH_W_TAIL: begin
                n_delay = dly_dec;
                if (dly_exp) begin
                    n_bit_count = bc_inc;
                    if (bc_inc >= 4'd8) begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end else begin
                        n_sda   = r_shift[7];
                        n_shift = {r_shift[6:0], 1'b0};
                        n_phase = PH_W_LOW;
                        n_delay = i2cm_pkg::f_ticks(r_cfg.mid_ticks);
                    end
                end
            end
            PH_R_LOW: begin
                n_delay = dly_dec;
                if (dly_exp) begin
                    n_scl   = 1'b1;
                    n_shift = {r_shift[6:0], i_entry.sda_in};
                    n_phase = PH_R_HIGH;
                    n_delay = i2cm_pkg::f_ticks(r_cfg.short_ticks);
                end
            end
            PH_R_HIGH: begin
                n_delay = dly_dec;
                if (dly_exp) begin
                    n_scl       = 1'b0;
                    n_bit_count = bc_inc;
                    if (bc_inc >= 4'd8) begin
                        n_rx     = r_shift;
                        n_sda_oe = 1'b1;
                        n_sda    = !r_ack_to_send;
                        n_phase  = PH_A_LOW;
                    end else begin
                        n_phase = PH_R_LOW;
                    end
                    n_delay = i2cm_pkg::f_ticks(r_cfg.mid_ticks);
                end
            end
            PH_A_LOW: begin
                n_delay = dly_dec;
                if (dly_exp) begin
                    n_scl   = 1'b1;
                    n_phase = PH_A_HIGH;
                    n_delay = r_ack_to_send ? i2cm_pkg::f_ticks(r_cfg.mid_ticks)
                                            : i2cm_pkg::f_ticks(r_cfg.long_ticks);
                end
            end
            PH_A_HIGH: begin
                n_delay = dly_dec;
                if (dly_exp) begin
                    n_scl   = 1'b0;
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end
            end
            PH_WA1: begin
                n_delay = dly_dec;
                if (dly_exp) begin
                    n_scl   = 1'b1;
                    n_phase = PH_WA2;
                    n_delay = i2cm_pkg::f_ticks(r_cfg.short_ticks);
                end
            end
            PH_WA2: begin
                n_delay = dly_dec;
                if (dly_exp) begin
                    n_phase = PH_WA_POLL;
                end
            end
            PH_WA_POLL: begin
                if (!i_entry.sda_in) begin
                    n_scl   = 1'b0;
                    n_fail  = 1'b0;
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end else if (poll_inc > {1'b0, r_cfg.ack_limit}) begin
                    n_fail   = 1'b1;
                    n_sda_oe = 1'b1;
                    n_scl    = 1'b0;
                    n_sda    = 1'b0;
                    n_phase  = PH_SP1;
                    n_delay  = i2cm_pkg::f_ticks(r_cfg.long_ticks);
                end else begin
                    n_poll = poll_inc[7:0];
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_bit_count   <= 4'd0;
            r_shift       <= 8'd0;
            r_delay       <= 8'd0;
            r_poll        <= 8'd0;
            r_scl         <= 1'b1;
            r_sda         <= 1'b1;
            r_sda_oe      <= 1'b1;
            r_ack_to_send <= 1'b0;
            r_fail        <= 1'b0;
            r_rx          <= 8'd0;
            r_out_valid   <= 1'b0;
            r_out_done    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase       <= n_phase;
                r_bit_count   <= n_bit_count;
                r_shift       <= n_shift;
                r_delay       <= n_delay;
                r_poll        <= n_poll;
                r_scl         <= n_scl;
                r_sda         <= n_sda;
                r_sda_oe      <= n_sda_oe;
                r_ack_to_send <= n_ack_to_send;
                r_fail        <= n_fail;
                r_rx          <= n_rx;
                r_out_done    <= done;
                r_out_valid   <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.scl_level  = r_scl;
    assign o_res.sda_level  = r_sda;
    assign o_res.sda_enable = r_sda_oe;
    assign o_res.busy_res   = (r_phase != PH_IDLE);
    assign o_res.done_res   = r_out_done;
    assign o_res.rx_byte    = r_rx;
    assign o_res.ack_failed = r_fail;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_done |-> (r_phase == PH_IDLE))
        else $error("done reported while still busy");

    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= 4'd8)
        else $error("bit count beyond one byte");

    a_idle_delay_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_delay == 8'd0))
        else $error("delay counter left running in idle");

    a_step_only_on_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pop |=> (r_phase == $past(r_phase)))
        else $error("phase advanced without a tick");

endmodule

`default_nettype wire

// File: sv/i2c_master_bit_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core
// I2C master bit engine: one timing tick in, one set of bus levels out.
//
// Each transfer on i_tick is one bus timing tick that may carry a command
// (start, stop, write byte, read byte, wait for ACK) and the sampled SDA
// level. Each tick gives exactly one transfer on o_res with the SCL and SDA
// drive levels, SDA enable, busy, done, the last received byte and the
// ack-failed flag. i_cfg writes the four delay and timeout registers and
// should only be used while the engine is idle.
// The front end classifies ticks into a two-entry queue; the back end runs
// one phase step per tick into a registered result stage. An accepted tick
// is held in the queue and then registered into the result stage, and one
// tick is taken per cycle when o_res.ready stays high. When the receiver
// stalls, the result holds, the queue fills and i_tick.ready falls once full.
// Reset (synchronous, active low) returns the engine to idle with SCL and
// SDA driven high and the delay registers at their default values.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core #(
    parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    i2cm_tick_if.sink   i_tick,
    i2cm_cfg_if.sink    i_cfg,
    i2cm_res_if.source  o_res
);

    logic             push;
    logic             push_ready;
    i2cm_pkg::t_entry push_entry;
    logic             q_valid;
    i2cm_pkg::t_entry q_entry;
    logic             pop;

    i2cm_front u_front (
        .i_tick       (i_tick),
        .o_push       (push),
        .o_entry      (push_entry),
        .i_push_ready (push_ready)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_data       (push_entry),
        .o_push_ready (push_ready),
        .o_valid      (q_valid),
        .o_data       (q_entry),
        .i_pop        (pop)
    );

    i2cm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_valid (q_valid),
        .i_entry (q_entry),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the I2C master bit engine core.
//
// Bus timing ticks are planned as well-formed transactions (start, address
// write, wait for ACK, data writes or reads, stop) mixed with stray commands,
// invalid codes and commands offered while busy. A cycle-exact model of the
// engine predicts the bus levels for every accepted tick, and each result
// transfer is compared field by field. The delay and timeout registers are
// reprogrammed between phases, including zero and full-scale settings, and
// both channels idle at random except in the final random phases.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PRINT_LIMIT  = 40;
    localparam int SETTLE_TICKS = 6;

    localparam logic [2:0] OP_RSVD5 = 3'd5;
    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    typedef enum logic [14:0] {
        S_IDLE     = 15'h0001,
        S_START_A  = 15'h0002,
        S_START_B  = 15'h0004,
        S_STOP_A   = 15'h0008,
        S_STOP_B   = 15'h0010,
        S_WR_LOW   = 15'h0020,
        S_WR_HIGH  = 15'h0040,
        S_WR_TAIL  = 15'h0080,
        S_RD_LOW   = 15'h0100,
        S_RD_HIGH  = 15'h0200,
        S_ACK_LOW  = 15'h0400,
        S_ACK_HIGH = 15'h0800,
        S_WA_SETUP = 15'h1000,
        S_WA_CLOCK = 15'h2000,
        S_WA_POLL  = 15'h4000
    } t_bus_phase;

    typedef struct packed {
        t_bus_phase ph;
        logic [3:0] bits;
        logic [7:0] shreg;
        logic [7:0] dly;
        logic [7:0] polls;
        logic       scl;
        logic       sda;
        logic       oe;
        logic       ack_sel;
        logic       fail;
        logic [7:0] rx;
    } t_bus_state;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] operation;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_bus_tick;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       oe;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       fail;
    } t_bus_levels;

    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       ack;
        logic [8:0] hold;
    } t_cmd_plan;

    logic clk;
    logic rst_n;

    i2cm_tick_if tick_if();
    i2cm_cfg_if  cfg_if();
    i2cm_res_if  res_if();

    i2c_master_bit_engine_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_tick  (tick_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    i2cm_pkg::t_cfg cfg;
    t_bus_state     gen_st;
    t_bus_state     chk_st;
    int             gen_hold_polls;
    t_bus_tick      tick_q[$];
    t_cmd_plan      cmd_plan_q[$];
    t_bus_levels    bus_levels_q[$];
    t_bus_tick      acc_tick;
    t_bus_tick      nxt_tick;
    t_bus_levels    want;
    int             sent_n;
    int             acc_n;
    int             mismatch_cnt;
    int             cycles;
    int             src_idle_pct;
    int             snk_idle_pct;

    function automatic t_bus_state reset_state();
        t_bus_state s;
        s       = '0;
        s.ph    = S_IDLE;
        s.scl   = 1'b1;
        s.sda   = 1'b1;
        s.oe    = 1'b1;
        return s;
    endfunction

    function automatic logic [7:0] at_least_one(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    function automatic logic count_down(inout logic [7:0] d);
        if (d > 8'd1) begin
            d = d - 8'd1;
            return 1'b0;
        end
        d = 8'd0;
        return 1'b1;
    endfunction

    // Advances the engine by one tick and returns the levels seen after it.
    function automatic t_bus_levels bus_step(inout t_bus_state s, input t_bus_tick t,
                                             input i2cm_pkg::t_cfg c);
        t_bus_levels r;
        logic        done_now;
        logic [8:0]  nxt;
        done_now = 1'b0;
        case (s.ph)
            S_IDLE: begin
                if (t.cmd_valid) begin
                    case (t.operation)
                        i2cm_pkg::OP_START: begin
                            s.oe = 1'b1; s.sda = 1'b1; s.scl = 1'b1;
                            s.ph = S_START_A; s.dly = at_least_one(c.long_ticks);
                        end
                        i2cm_pkg::OP_STOP: begin
                            s.oe = 1'b1; s.scl = 1'b0; s.sda = 1'b0;
                            s.ph = S_STOP_A; s.dly = at_least_one(c.long_ticks);
                        end
                        i2cm_pkg::OP_WRITE: begin
                            s.oe = 1'b1; s.scl = 1'b0; s.bits = 4'd0;
                            s.sda = t.tx_byte[7]; s.shreg = {t.tx_byte[6:0], 1'b0};
                            s.ph = S_WR_LOW; s.dly = at_least_one(c.mid_ticks);
                        end
                        i2cm_pkg::OP_READ: begin
                            s.oe = 1'b0; s.scl = 1'b0; s.shreg = 8'd0; s.bits = 4'd0;
                            s.ack_sel = t.send_ack;
                            s.ph = S_RD_LOW; s.dly = at_least_one(c.mid_ticks);
                        end
                        i2cm_pkg::OP_WAIT: begin
                            s.oe = 1'b0; s.sda = 1'b1; s.polls = 8'd0;
                            s.ph = S_WA_SETUP; s.dly = at_least_one(c.short_ticks);
                        end
                        default: ;
                    endcase
                end
            end
            S_START_A: begin
                if (count_down(s.dly)) begin
                    s.sda = 1'b0;
                    s.ph = S_START_B; s.dly = at_least_one(c.long_ticks);
                end
            end
            S_START_B: begin
                if (count_down(s.dly)) begin
                    s.scl = 1'b0; s.ph = S_IDLE; done_now = 1'b1;
                end
            end
            S_STOP_A: begin
                if (count_down(s.dly)) begin
                    s.scl = 1'b1; s.sda = 1'b1;
                    s.ph = S_STOP_B; s.dly = at_least_one(c.long_ticks);
                end
            end
            S_STOP_B: begin
                if (count_down(s.dly)) begin
                    s.ph = S_IDLE; done_now = 1'b1;
                end
            end
            S_WR_LOW: begin
                if (count_down(s.dly)) begin
                    s.scl = 1'b1;
                    s.ph = S_WR_HIGH; s.dly = at_least_one(c.mid_ticks);
                end
            end
            S_WR_HIGH: begin
                if (count_down(s.dly)) begin
                    s.scl = 1'b0;
                    s.ph = S_WR_TAIL; s.dly = at_least_one(c.mid_ticks);
                end
            end
            S_WR_TAIL: begin
                if (count_down(s.dly)) begin
                    s.bits = s.bits + 4'd1;
                    if (s.bits >= 4'd8) begin
                        s.ph = S_IDLE; done_now = 1'b1;
                    end else begin
                        s.sda = s.shreg[7]; s.shreg = {s.shreg[6:0], 1'b0};
                        s.ph = S_WR_LOW; s.dly = at_least_one(c.mid_ticks);
                    end
                end
            end
            S_RD_LOW: begin
                if (count_down(s.dly)) begin
                    s.scl = 1'b1; s.shreg = {s.shreg[6:0], t.sda_in};
                    s.ph = S_RD_HIGH; s.dly = at_least_one(c.short_ticks);
                end
            end
            S_RD_HIGH: begin
                if (count_down(s.dly)) begin
                    s.scl = 1'b0;
                    s.bits = s.bits + 4'd1;
                    if (s.bits >= 4'd8) begin
                        s.rx = s.shreg; s.oe = 1'b1; s.sda = !s.ack_sel;
                        s.ph = S_ACK_LOW; s.dly = at_least_one(c.mid_ticks);
                    end else begin
                        s.ph = S_RD_LOW; s.dly = at_least_one(c.mid_ticks);
                    end
                end
            end
            S_ACK_LOW: begin
                if (count_down(s.dly)) begin
                    s.scl = 1'b1; s.ph = S_ACK_HIGH;
                    s.dly = at_least_one(s.ack_sel ? c.mid_ticks : c.long_ticks);
                end
            end
            S_ACK_HIGH: begin
                if (count_down(s.dly)) begin
                    s.scl = 1'b0; s.ph = S_IDLE; done_now = 1'b1;
                end
            end
            S_WA_SETUP: begin
                if (count_down(s.dly)) begin
                    s.scl = 1'b1;
                    s.ph = S_WA_CLOCK; s.dly = at_least_one(c.short_ticks);
                end
            end
            S_WA_CLOCK: begin
                if (count_down(s.dly)) begin
                    s.ph = S_WA_POLL;
                end
            end
            S_WA_POLL: begin
                if (!t.sda_in) begin
                    s.scl = 1'b0; s.fail = 1'b0; s.ph = S_IDLE; done_now = 1'b1;
                end else begin
                    nxt = {1'b0, s.polls} + 9'd1;
                    if (nxt > {1'b0, c.ack_limit}) begin
                        s.fail = 1'b1;
                        s.oe = 1'b1; s.scl = 1'b0; s.sda = 1'b0;
                        s.ph = S_STOP_A; s.dly = at_least_one(c.long_ticks);
                    end else begin
                        s.polls = nxt[7:0];
                    end
                end
            end
            default: s.ph = S_IDLE;
        endcase
        r.scl  = s.scl;
        r.sda  = s.sda;
        r.oe   = s.oe;
        r.busy = (s.ph != S_IDLE);
        r.done = done_now;
        r.rx   = s.rx;
        r.fail = s.fail;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_LIMIT) begin
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what,
                     exp_v, got_v);
        end
    endtask

    task automatic plan_cmd(input logic [2:0] op, input logic [7:0] data, input logic ack,
                            input int hold);
        t_cmd_plan p;
        p.op   = op;
        p.data = data;
        p.ack  = ack;
        p.hold = hold[8:0];
        cmd_plan_q.push_back(p);
    endtask

    // Mostly a prompt ACK; sometimes SDA stays high past any timeout limit.
    function automatic int pick_hold();
        return ($urandom_range(9) < 8) ? int'($urandom_range(0, 3)) : 300;
    endfunction

    task automatic plan_transaction();
        logic [7:0] addr;
        int         n;
        int         i;
        addr = 8'($urandom);
        n    = int'($urandom_range(1, 3));
        if ($urandom_range(9) < 8) begin
            plan_cmd(i2cm_pkg::OP_START, 8'($urandom), 1'($urandom_range(1)), 0);
            plan_cmd(i2cm_pkg::OP_WRITE, addr, 1'($urandom_range(1)), 0);
            plan_cmd(i2cm_pkg::OP_WAIT, 8'($urandom), 1'($urandom_range(1)), pick_hold());
            for (i = 0; i < n; i++) begin
                if (addr[0]) begin
                    plan_cmd(i2cm_pkg::OP_READ, 8'($urandom), (i < n - 1), 0);
                end else begin
                    plan_cmd(i2cm_pkg::OP_WRITE, 8'($urandom), 1'($urandom_range(1)), 0);
                    plan_cmd(i2cm_pkg::OP_WAIT, 8'($urandom), 1'($urandom_range(1)),
                             pick_hold());
                end
            end
            if ($urandom_range(4) == 0) begin
                plan_cmd(i2cm_pkg::OP_START, 8'($urandom), 1'($urandom_range(1)), 0);
            end
            plan_cmd(i2cm_pkg::OP_STOP, 8'($urandom), 1'($urandom_range(1)), 0);
        end else begin
            plan_cmd(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                     pick_hold());
        end
    endtask

    // Builds the next tick from the plan, following the engine so that planned
    // commands land while it is idle and SDA answers the ACK polls as planned.
    task automatic gen_tick();
        t_bus_tick t;
        t_cmd_plan p;
        t.cmd_valid = 1'b0;
        t.operation = 3'($urandom_range(7));
        t.tx_byte   = 8'($urandom);
        t.send_ack  = 1'($urandom_range(1));
        t.sda_in    = 1'($urandom_range(1));
        if (gen_st.ph == S_IDLE) begin
            if (cmd_plan_q.size() != 0 && $urandom_range(99) < 70) begin
                p              = cmd_plan_q.pop_front();
                t.cmd_valid    = 1'b1;
                t.operation    = p.op;
                t.tx_byte      = p.data;
                t.send_ack     = p.ack;
                gen_hold_polls = int'(p.hold);
            end
        end else begin
            t.cmd_valid = ($urandom_range(99) < 15);
            if (gen_st.ph == S_WA_POLL) begin
                t.sda_in = (gen_hold_polls != 0);
                if (gen_hold_polls != 0) gen_hold_polls--;
            end
        end
        void'(bus_step(gen_st, t, cfg));
        tick_q.push_back(t);
        sent_n++;
    endtask

    task automatic run_phase(input int n, input bit rnd);
        int k;
        k = 0;
        while (k < n || cmd_plan_q.size() != 0 || gen_st.ph != S_IDLE) begin
            if (rnd && k < n && cmd_plan_q.size() == 0) plan_transaction();
            gen_tick();
            k++;
        end
        while (acc_n != sent_n || bus_levels_q.size() != 0) @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(input i2cm_pkg::t_cfg_idx idx, input logic [7:0] v);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= v;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            i2cm_pkg::CFG_LONG:  cfg.long_ticks  = v;
            i2cm_pkg::CFG_MID:   cfg.mid_ticks   = v;
            i2cm_pkg::CFG_SHORT: cfg.short_ticks = v;
            i2cm_pkg::CFG_LIMIT: cfg.ack_limit   = v;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [7:0] l, input logic [7:0] m, input logic [7:0] s,
                            input logic [7:0] lim);
        write_reg(i2cm_pkg::CFG_LONG, l);
        write_reg(i2cm_pkg::CFG_MID, m);
        write_reg(i2cm_pkg::CFG_SHORT, s);
        write_reg(i2cm_pkg::CFG_LIMIT, lim);
    endtask

    task automatic set_idling(input int src, input int snk);
        src_idle_pct = src;
        snk_idle_pct = snk;
    endtask

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Tick driver; the model follows each accepted transfer.
    always @(posedge clk) begin
        if (!rst_n) begin
            tick_if.valid <= 1'b0;
        end else begin
            if (tick_if.valid && tick_if.ready) begin
                acc_tick.cmd_valid = tick_if.cmd_valid;
                acc_tick.operation = tick_if.operation;
                acc_tick.tx_byte   = tick_if.tx_byte;
                acc_tick.send_ack  = tick_if.send_ack;
                acc_tick.sda_in    = tick_if.sda_in;
                bus_levels_q.push_back(bus_step(chk_st, acc_tick, cfg));
                acc_n++;
            end
            if (!tick_if.valid || tick_if.ready) begin
                if (tick_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    nxt_tick = tick_q.pop_front();
                    tick_if.cmd_valid <= nxt_tick.cmd_valid;
                    tick_if.operation <= nxt_tick.operation;
                    tick_if.tx_byte   <= nxt_tick.tx_byte;
                    tick_if.send_ack  <= nxt_tick.send_ack;
                    tick_if.sda_in    <= nxt_tick.sda_in;
                    tick_if.valid     <= 1'b1;
                end else begin
                    tick_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
            if (res_if.valid && res_if.ready) begin
                if (bus_levels_q.size() == 0) begin
                    report_mismatch("unexpected result transfer", 0, 1);
                end else begin
                    want = bus_levels_q.pop_front();
                    if (res_if.scl_level !== want.scl)
                        report_mismatch("scl_level", int'(want.scl),
                                        int'(res_if.scl_level));
                    if (res_if.sda_level !== want.sda)
                        report_mismatch("sda_level", int'(want.sda),
                                        int'(res_if.sda_level));
                    if (res_if.sda_enable !== want.oe)
                        report_mismatch("sda_enable", int'(want.oe),
                                        int'(res_if.sda_enable));
                    if (res_if.busy_res !== want.busy)
                        report_mismatch("busy_res", int'(want.busy),
                                        int'(res_if.busy_res));
                    if (res_if.done_res !== want.done)
                        report_mismatch("done_res", int'(want.done),
                                        int'(res_if.done_res));
                    if (res_if.rx_byte !== want.rx)
                        report_mismatch("rx_byte", int'(want.rx), int'(res_if.rx_byte));
                    if (res_if.ack_failed !== want.fail)
                        report_mismatch("ack_failed", int'(want.fail),
                                        int'(res_if.ack_failed));
                end
            end
        end
    end

    initial begin
        int p;
        rst_n             = 1'b0;
        cycles            = 0;
        sent_n            = 0;
        acc_n             = 0;
        mismatch_cnt      = 0;
        gen_hold_polls    = 0;
        tick_if.valid     = 1'b0;
        tick_if.cmd_valid = 1'b0;
        tick_if.operation = i2cm_pkg::OP_START;
        tick_if.tx_byte   = 8'd0;
        tick_if.send_ack  = 1'b0;
        tick_if.sda_in    = 1'b1;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = i2cm_pkg::CFG_LONG;
        cfg_if.data       = 8'd0;
        res_if.ready      = 1'b0;
        cfg.long_ticks    = i2cm_pkg::LONG_PHASE_RST;
        cfg.mid_ticks     = i2cm_pkg::MID_PHASE_RST;
        cfg.short_ticks   = i2cm_pkg::SHORT_PHASE_RST;
        cfg.ack_limit     = i2cm_pkg::ACK_LIMIT_RST;
        gen_st            = reset_state();
        chk_st            = reset_state();
        set_idling(21, 58);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Start, wait, read with NACK and stop at the reset timing.
        plan_cmd(i2cm_pkg::OP_START, 8'h00, 1'b0, 0);
        plan_cmd(i2cm_pkg::OP_WAIT, 8'h00, 1'b0, 1);
        plan_cmd(i2cm_pkg::OP_READ, 8'h00, 1'b0, 0);
        plan_cmd(i2cm_pkg::OP_STOP, 8'h00, 1'b0, 0);
        run_phase(0, 1'b0);

        // Directed commands at the shortest timing.
        set_regs(8'd1, 8'd1, 8'd1, 8'd1);
        plan_cmd(i2cm_pkg::OP_START, 8'h00, 1'b0, 0);
        plan_cmd(i2cm_pkg::OP_WRITE, 8'h00, 1'b0, 0);
        plan_cmd(i2cm_pkg::OP_WRITE, 8'hFF, 1'b1, 0);
        plan_cmd(i2cm_pkg::OP_WRITE, 8'hA5, 1'b0, 0);
        plan_cmd(i2cm_pkg::OP_WAIT, 8'h00, 1'b0, 0);
        plan_cmd(i2cm_pkg::OP_WAIT, 8'h00, 1'b0, 1);
        plan_cmd(i2cm_pkg::OP_WAIT, 8'h00, 1'b0, 5);
        plan_cmd(i2cm_pkg::OP_READ, 8'h00, 1'b1, 0);
        plan_cmd(i2cm_pkg::OP_READ, 8'hFF, 1'b0, 0);
        plan_cmd(OP_RSVD5, 8'hFF, 1'b1, 0);
        plan_cmd(OP_RSVD6, 8'h00, 1'b0, 0);
        plan_cmd(OP_RSVD7, 8'h5A, 1'b1, 0);
        plan_cmd(i2cm_pkg::OP_STOP, 8'h00, 1'b0, 0);
        plan_cmd(i2cm_pkg::OP_STOP, 8'h00, 1'b0, 0);
        run_phase(0, 1'b0);

        // Zero registers act as one tick; a zero limit fails on the first high poll.
        set_idling(58, 21);
        set_regs(8'd0, 8'd0, 8'd0, 8'd0);
        plan_cmd(i2cm_pkg::OP_WAIT, 8'h00, 1'b0, 1);
        run_phase(100, 1'b1);

        // Full-scale limit: the wait times out only after 256 high polls.
        set_regs(8'd1, 8'd1, 8'd1, 8'd255);
        plan_cmd(i2cm_pkg::OP_WAIT, 8'h00, 1'b0, 300);
        run_phase(0, 1'b0);

        // Full-scale long phase: NACK high time of 255 ticks.
        set_regs(8'd255, 8'd1, 8'd1, 8'd1);
        plan_cmd(i2cm_pkg::OP_READ, 8'h00, 1'b0, 0);
        run_phase(0, 1'b0);

        set_idling(0, 0);
        for (p = 0; p < 2; p++) begin
            set_regs(8'($urandom_range(1, 4)), 8'($urandom_range(1, 3)),
                     8'($urandom_range(1, 4)), 8'($urandom_range(0, 8)));
            run_phase(40, 1'b1);
        end

        if (mismatch_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
